[src/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define UPR_ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("ranger assertion failed");

// Same, on the block's own clock and reset.
`define UPR_ASSERT(label, prop) `UPR_ASSERT_CLK(label, aclk, aresetn, prop)

`endif

[src/upr_pkg.sv]
package upr_pkg;

    typedef logic [13:0] dist_t;

    // ping sequencer phases
    typedef enum logic [1:0] {
        PH_IDLE       = 2'd0,
        PH_TRIG       = 2'd1,
        PH_WAIT_START = 2'd2,
        PH_WAIT_END   = 2'd3
    } phase_t;

    // top level control
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_CLAMP,
        ST_MED_START,
        ST_MED_WAIT,
        ST_EMA_MUL,
        ST_EMA_SUM,
        ST_OUT
    } top_state_t;

    // median unit control
    typedef enum logic [1:0] {
        M_IDLE,
        M_FEED,
        M_DRAIN
    } med_state_t;

    typedef enum logic [2:0] {
        CFG_PING_INTERVAL = 3'd0,
        CFG_ECHO_TIMEOUT  = 3'd1,
        CFG_MIN_DISTANCE  = 3'd2,
        CFG_MAX_DISTANCE  = 3'd3,
        CFG_SMOOTH_GAIN   = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic  start;
        dist_t value;
    } med_req_t;

    typedef struct packed {
        logic  done;
        dist_t median;
    } med_rsp_t;

    localparam logic [31:0] TRIG_PULSE_US         = 32'd12;
    localparam logic [31:0] ECHO_START_TIMEOUT_US = 32'd50000;
    localparam logic [14:0] CM_PER_US_Q16         = 15'd17983;
    localparam logic [8:0]  GAIN_ONE              = 9'd256;

    localparam logic [15:0] PING_INTERVAL_RST = 16'd60;
    localparam logic [15:0] ECHO_TIMEOUT_RST  = 16'd30000;
    localparam dist_t       MIN_DISTANCE_RST  = 14'd32;
    localparam dist_t       MAX_DISTANCE_RST  = 14'd6400;
    localparam logic [8:0]  SMOOTH_GAIN_RST   = 9'd77;

endpackage

[src/ultrasonic_ping_ranger_median_ema.sv]
// Ultrasonic ping ranger: each accepted request is one time sample (ms and us
// counts plus the echo level) and yields exactly one result with the trigger
// level, the distance recorded on this sample if any, and the smoothed
// distance. One request at a time. A sample that records nothing passes
// through the accept, evaluate and output steps. A sample that records a
// distance also passes through the clamp, median start, median wait, EMA
// multiply and EMA sum steps, with the clamp step skipped on a timeout.
// Most of that time goes to the median sorting chain: it feeds the window in
// one entry per cycle, then lets the chain settle. A result that waits for
// the previous one to leave the output register stalls in the output step.
// A finished result sits in the output register while the next request is
// accepted. Configuration writes are taken at any time and are meant to
// happen while the block is idle.
module ultrasonic_ping_ranger_median_ema
    import upr_pkg::*;
#(
    parameter int WINDOW_SIZE = 5
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_time_ms,
    input  logic [31:0] s_time_us,
    input  logic        s_echo_level,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_trig_level,
    output logic        m_sample_valid,
    output logic        m_timed_out,
    output logic [13:0] m_raw_distance,
    output logic [13:0] m_smoothed_distance
);

    // configuration
    logic [15:0] ping_interval_reg;
    logic [15:0] echo_timeout_reg;
    dist_t       min_dist_reg;
    dist_t       max_dist_reg;
    logic [8:0]  gain_reg;

    // control
    top_state_t  state_reg, state_next;
    phase_t      phase_reg, phase_next;
    logic        trig_reg, trig_next;
    logic [31:0] last_ping_reg, last_ping_next;
    logic [31:0] trig_start_reg, trig_start_next;
    logic [31:0] echo_start_reg, echo_start_next;
    dist_t       smoothed_reg, smoothed_next;
    logic        m_valid_reg, m_valid_next;

    // payload
    logic [31:0] in_ms_reg, in_ms_next;
    logic [31:0] in_us_reg, in_us_next;
    logic        in_echo_reg, in_echo_next;
    logic [30:0] cm_reg, cm_next;
    logic        rec_reg, rec_next;
    logic        tmo_reg, tmo_next;
    dist_t       raw_reg, raw_next;
    dist_t       med_reg, med_next;
    logic [22:0] p_new_reg, p_new_next;
    logic [22:0] p_old_reg, p_old_next;
    logic        m_trig_reg, m_sample_reg, m_tmo_reg;
    dist_t       m_raw_reg, m_smooth_reg;

    logic [31:0] d_ms, d_trig_us, d_echo_us;
    logic [46:0] prod;
    logic [30:0] cm_lo;
    logic [8:0]  gain_sat;
    logic [8:0]  gain_inv;
    logic [23:0] ema_sum;
    logic        out_load;

    med_req_t med_req;
    med_rsp_t med_rsp;

    assign d_ms      = in_ms_reg - last_ping_reg;
    assign d_trig_us = in_us_reg - trig_start_reg;
    assign d_echo_us = in_us_reg - echo_start_reg;
    assign prod      = {15'd0, d_echo_us} * {32'd0, CM_PER_US_Q16};
    assign cm_lo     = (cm_reg < {17'd0, min_dist_reg}) ? {17'd0, min_dist_reg} : cm_reg;
    assign gain_sat  = (gain_reg > GAIN_ONE) ? GAIN_ONE : gain_reg;
    assign gain_inv  = GAIN_ONE - gain_sat;
    assign ema_sum   = {1'b0, p_new_reg} + {1'b0, p_old_reg} + 24'd128;

    always_comb begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        trig_next       = trig_reg;
        last_ping_next  = last_ping_reg;
        trig_start_next = trig_start_reg;
        echo_start_next = echo_start_reg;
        smoothed_next   = smoothed_reg;
        in_ms_next      = in_ms_reg;
        in_us_next      = in_us_reg;
        in_echo_next    = in_echo_reg;
        cm_next         = cm_reg;
        rec_next        = rec_reg;
        tmo_next        = tmo_reg;
        raw_next        = raw_reg;
        med_next        = med_reg;
        p_new_next      = p_new_reg;
        p_old_next      = p_old_reg;
        med_req.start   = 1'b0;
        med_req.value   = raw_reg;
        out_load        = 1'b0;
        s_ready         = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    in_ms_next   = s_time_ms;
                    in_us_next   = s_time_us;
                    in_echo_next = s_echo_level;
                    state_next   = ST_EVAL;
                end
            end
            ST_EVAL: begin
                rec_next = 1'b0;
                tmo_next = 1'b0;
                raw_next = '0;
                cm_next  = prod[46:16];
                unique case (phase_reg)
                    PH_IDLE: begin
                        if (d_ms >= {16'd0, ping_interval_reg} && !in_echo_reg) begin
                            phase_next      = PH_TRIG;
                            trig_next       = 1'b1;
                            trig_start_next = in_us_reg;
                        end
                    end
                    PH_TRIG: begin
                        if (d_trig_us >= TRIG_PULSE_US) begin
                            trig_next  = 1'b0;
                            phase_next = PH_WAIT_START;
                        end
                    end
                    PH_WAIT_START: begin
                        if (in_echo_reg) begin
                            echo_start_next = in_us_reg;
                            phase_next      = PH_WAIT_END;
                        end else if (d_trig_us > ECHO_START_TIMEOUT_US) begin
                            rec_next = 1'b1;
                            tmo_next = 1'b1;
                        end
                    end
                    PH_WAIT_END: begin
                        if (!in_echo_reg) begin
                            rec_next = 1'b1;
                        end else if (d_echo_us > {16'd0, echo_timeout_reg}) begin
                            rec_next = 1'b1;
                            tmo_next = 1'b1;
                        end
                    end
                    default: phase_next = PH_IDLE;
                endcase
                // end of a ping: either an echo measured or a timeout
                if (rec_next) begin
                    phase_next     = PH_IDLE;
                    last_ping_next = in_ms_reg;
                    if (tmo_next) begin
                        raw_next   = max_dist_reg;
                        state_next = ST_MED_START;
                    end else begin
                        state_next = ST_CLAMP;
                    end
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_CLAMP: begin
                // max clamp applied last so it wins over min
                raw_next   = (cm_lo > {17'd0, max_dist_reg}) ? max_dist_reg : cm_lo[13:0];
                state_next = ST_MED_START;
            end
            ST_MED_START: begin
                med_req.start = 1'b1;
                state_next    = ST_MED_WAIT;
            end
            ST_MED_WAIT: begin
                if (med_rsp.done) begin
                    med_next   = med_rsp.median;
                    state_next = ST_EMA_MUL;
                end
            end
            ST_EMA_MUL: begin
                p_new_next = {14'd0, gain_sat} * {9'd0, med_reg};
                p_old_next = {14'd0, gain_inv} * {9'd0, smoothed_reg};
                state_next = ST_EMA_SUM;
            end
            ST_EMA_SUM: begin
                smoothed_next = ema_sum[21:8];
                state_next    = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            phase_reg      <= PH_IDLE;
            trig_reg       <= 1'b0;
            last_ping_reg  <= '0;
            trig_start_reg <= '0;
            echo_start_reg <= '0;
            smoothed_reg   <= MAX_DISTANCE_RST;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            trig_reg       <= trig_next;
            last_ping_reg  <= last_ping_next;
            trig_start_reg <= trig_start_next;
            echo_start_reg <= echo_start_next;
            smoothed_reg   <= smoothed_next;
            m_valid_reg    <= m_valid_next;
        end
        in_ms_reg   <= in_ms_next;
        in_us_reg   <= in_us_next;
        in_echo_reg <= in_echo_next;
        cm_reg      <= cm_next;
        rec_reg     <= rec_next;
        tmo_reg     <= tmo_next;
        raw_reg     <= raw_next;
        med_reg     <= med_next;
        p_new_reg   <= p_new_next;
        p_old_reg   <= p_old_next;
        if (out_load) begin
            m_trig_reg   <= trig_reg;
            m_sample_reg <= rec_reg;
            m_tmo_reg    <= tmo_reg;
            m_raw_reg    <= raw_reg;
            m_smooth_reg <= smoothed_reg;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ping_interval_reg <= PING_INTERVAL_RST;
            echo_timeout_reg  <= ECHO_TIMEOUT_RST;
            min_dist_reg      <= MIN_DISTANCE_RST;
            max_dist_reg      <= MAX_DISTANCE_RST;
            gain_reg          <= SMOOTH_GAIN_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_PING_INTERVAL: ping_interval_reg <= cfg_data;
                CFG_ECHO_TIMEOUT:  echo_timeout_reg  <= cfg_data;
                CFG_MIN_DISTANCE:  min_dist_reg      <= cfg_data[13:0];
                CFG_MAX_DISTANCE:  max_dist_reg      <= cfg_data[13:0];
                CFG_SMOOTH_GAIN:   gain_reg          <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    upr_median #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_median (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (med_req),
        .rsp     (med_rsp)
    );

    assign cfg_ready           = 1'b1;
    assign m_valid             = m_valid_reg;
    assign m_trig_level        = m_trig_reg;
    assign m_sample_valid      = m_sample_reg;
    assign m_timed_out         = m_tmo_reg;
    assign m_raw_distance      = m_raw_reg;
    assign m_smoothed_distance = m_smooth_reg;

endmodule

[src/upr_sort_cell.sv]
module upr_sort_cell
    import upr_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  clear,
    input  logic  in_valid,
    input  dist_t in_value,
    output dist_t held_value,
    output logic  out_valid,
    output dist_t out_value
);

    logic  held_valid_reg, held_valid_next;
    dist_t held_reg, held_next;
    logic  out_valid_reg, out_valid_next;
    dist_t out_reg, out_next;

    // Keeps the smallest value seen, passes everything larger down the chain.
    always_comb begin
        held_valid_next = held_valid_reg;
        held_next       = held_reg;
        out_valid_next  = 1'b0;
        out_next        = out_reg;
        if (clear) begin
            held_valid_next = 1'b0;
        end else if (in_valid) begin
            if (!held_valid_reg) begin
                held_valid_next = 1'b1;
                held_next       = in_value;
            end else if (in_value < held_reg) begin
                held_next      = in_value;
                out_next       = held_reg;
                out_valid_next = 1'b1;
            end else begin
                out_next       = in_value;
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            held_valid_reg <= held_valid_next;
            out_valid_reg  <= out_valid_next;
        end
        held_reg <= held_next;
        out_reg  <= out_next;
    end

    assign held_value = held_reg;
    assign out_valid  = out_valid_reg;
    assign out_value  = out_reg;

endmodule

[src/upr_median.sv]
module upr_median
    import upr_pkg::*;
#(
    parameter int WINDOW_SIZE = 5
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  med_req_t req,
    output med_rsp_t rsp
);

    localparam int CW  = $clog2(WINDOW_SIZE);
    localparam int MID = WINDOW_SIZE / 2;

    med_state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    // Window kept as a shift line: the oldest entry falls off the end, which
    // gives the same contents as overwriting it in a circular buffer.
    dist_t win_reg [WINDOW_SIZE];

    logic  chain_valid [WINDOW_SIZE];
    dist_t chain_value [WINDOW_SIZE];
    dist_t held        [WINDOW_SIZE];
    logic  feed;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        feed       = 1'b0;
        rsp.done   = 1'b0;
        rsp.median = held[MID];
        unique case (state_reg)
            M_IDLE: begin
                if (req.start) begin
                    state_next = M_FEED;
                    cnt_next   = '0;
                end
            end
            M_FEED: begin
                feed = 1'b1;
                if (cnt_reg == CW'(WINDOW_SIZE - 1)) begin
                    state_next = M_DRAIN;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            M_DRAIN: begin
                // last value may need to pass down the whole chain of cells to settle
                if (cnt_reg == CW'(WINDOW_SIZE - 1)) begin
                    rsp.done   = 1'b1;
                    state_next = M_IDLE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default: state_next = M_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= M_IDLE;
            cnt_reg   <= '0;
            for (int i = 0; i < WINDOW_SIZE; i++) begin
                win_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (req.start && state_reg == M_IDLE) begin
                win_reg[0] <= req.value;
                for (int i = 1; i < WINDOW_SIZE; i++) begin
                    win_reg[i] <= win_reg[i-1];
                end
            end else if (feed) begin
                // rotate once per cycle; a full pass restores the order
                win_reg[0] <= win_reg[WINDOW_SIZE-1];
                for (int i = 1; i < WINDOW_SIZE; i++) begin
                    win_reg[i] <= win_reg[i-1];
                end
            end
        end
    end

    assign chain_valid[0] = feed;
    assign chain_value[0] = win_reg[WINDOW_SIZE-1];

    for (genvar i = 0; i < WINDOW_SIZE; i++) begin : g_cell
        if (i < WINDOW_SIZE - 1) begin : g_mid
            upr_sort_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .clear      (req.start),
                .in_valid   (chain_valid[i]),
                .in_value   (chain_value[i]),
                .held_value (held[i]),
                .out_valid  (chain_valid[i+1]),
                .out_value  (chain_value[i+1])
            );
        end else begin : g_last
            upr_sort_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .clear      (req.start),
                .in_valid   (chain_valid[i]),
                .in_value   (chain_value[i]),
                .held_value (held[i]),
                .out_valid  (),
                .out_value  ()
            );
        end
    end

endmodule

[src/upr_checker.sv]
`include "assert_macros.svh"

module upr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_trig_level,
    input logic        m_sample_valid,
    input logic        m_timed_out,
    input logic [13:0] m_raw_distance,
    input logic [13:0] m_smoothed_distance
);

    // a stalled result holds
    `UPR_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_raw_distance) && $stable(m_smoothed_distance) && $stable(m_sample_valid))

    // no recorded sample means no timeout flag and a zero distance
    `UPR_ASSERT(a_no_sample_zero, m_valid && !m_sample_valid |-> !m_timed_out && m_raw_distance == 14'd0)

    // a distance is only recorded while waiting for the echo, trigger low
    `UPR_ASSERT(a_sample_trig_low, m_valid && m_sample_valid |-> !m_trig_level)

    // one request in flight: the block is busy right after an accept
    `UPR_ASSERT(a_busy_after_accept, s_valid && s_ready |=> !s_ready)

endmodule

bind ultrasonic_ping_ranger_median_ema upr_checker u_upr_checker (.*);

[bench/tb_ultrasonic_ping_ranger_median_ema.sv]
module tb_ultrasonic_ping_ranger_median_ema;
    import upr_pkg::*;

    localparam int WINDOW           = 5;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int SETTLE_CYCLES    = 40;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS      = 205;
    // index past the register list, must be ignored
    localparam logic [2:0] CFG_STRAY_INDEX = 3'd7;

    typedef struct packed {
        logic  trig;
        logic  valid;
        logic  tmo;
        dist_t raw;
        dist_t smooth;
    } ranger_result_t;

    class ranger_scoreboard #(int DEPTH = 5);
        logic [15:0] ping_interval;
        logic [15:0] echo_timeout;
        dist_t       min_dist;
        dist_t       max_dist;
        logic [8:0]  gain;
        phase_t      phase;
        logic [31:0] last_ping_ms;
        logic [31:0] trig_start_us;
        logic [31:0] echo_start_us;
        dist_t       window [DEPTH];
        int unsigned wr_ptr;
        dist_t       smoothed;
        logic        trig;
        ranger_result_t pending [$];
        int          mismatches;

        function new();
            ping_interval = PING_INTERVAL_RST;
            echo_timeout  = ECHO_TIMEOUT_RST;
            min_dist      = MIN_DISTANCE_RST;
            max_dist      = MAX_DISTANCE_RST;
            gain          = SMOOTH_GAIN_RST;
            phase         = PH_IDLE;
            last_ping_ms  = '0;
            trig_start_us = '0;
            echo_start_us = '0;
            foreach (window[i]) window[i] = '0;
            wr_ptr        = 0;
            smoothed      = MAX_DISTANCE_RST;
            trig          = 1'b0;
            mismatches    = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] data);
            case (idx)
                CFG_PING_INTERVAL: ping_interval = data;
                CFG_ECHO_TIMEOUT:  echo_timeout  = data;
                CFG_MIN_DISTANCE:  min_dist      = data[13:0];
                CFG_MAX_DISTANCE:  max_dist      = data[13:0];
                CFG_SMOOTH_GAIN:   gain          = data[8:0];
                default: ;
            endcase
        endfunction

        function void note_sample(logic [31:0] now_ms, logic [31:0] now_us, logic echo);
            logic           recorded;
            logic           from_timeout;
            dist_t          rec_distance;
            logic [31:0]    elapsed;
            logic [63:0]    scaled;
            dist_t          sorted [DEPTH];
            dist_t          key;
            int             j;
            logic [31:0]    g;
            logic [31:0]    blend;
            ranger_result_t r;
            recorded     = 1'b0;
            from_timeout = 1'b0;
            rec_distance = '0;
            case (phase)
                PH_IDLE: begin
                    if (now_ms - last_ping_ms >= 32'(ping_interval) && !echo) begin
                        phase         = PH_TRIG;
                        trig          = 1'b1;
                        trig_start_us = now_us;
                    end
                end
                PH_TRIG: begin
                    if (now_us - trig_start_us >= TRIG_PULSE_US) begin
                        trig  = 1'b0;
                        phase = PH_WAIT_START;
                    end
                end
                PH_WAIT_START: begin
                    if (echo) begin
                        echo_start_us = now_us;
                        phase         = PH_WAIT_END;
                    end else if (now_us - trig_start_us > ECHO_START_TIMEOUT_US) begin
                        recorded     = 1'b1;
                        from_timeout = 1'b1;
                        rec_distance = max_dist;
                    end
                end
                default: begin
                    elapsed = now_us - echo_start_us;
                    if (!echo) begin
                        scaled = (64'(elapsed) * 64'(CM_PER_US_Q16)) >> 16;
                        // min clamp first, so max wins when the two cross
                        if (scaled < 64'(min_dist)) scaled = 64'(min_dist);
                        if (scaled > 64'(max_dist)) scaled = 64'(max_dist);
                        recorded     = 1'b1;
                        rec_distance = scaled[13:0];
                    end else if (elapsed > 32'(echo_timeout)) begin
                        recorded     = 1'b1;
                        from_timeout = 1'b1;
                        rec_distance = max_dist;
                    end
                end
            endcase
            if (recorded) begin
                window[wr_ptr] = rec_distance;
                wr_ptr = (wr_ptr + 1) % DEPTH;
                sorted = window;
                for (int i = 1; i < DEPTH; i++) begin
                    key = sorted[i];
                    j   = i - 1;
                    while (j >= 0 && sorted[j] > key) begin
                        sorted[j + 1] = sorted[j];
                        j--;
                    end
                    sorted[j + 1] = key;
                end
                g = (gain > GAIN_ONE) ? 32'(GAIN_ONE) : 32'(gain);
                blend = g * 32'(sorted[DEPTH / 2]) + (32'(GAIN_ONE) - g) * 32'(smoothed)
                        + 32'd128;
                smoothed     = blend[21:8];
                phase        = PH_IDLE;
                last_ping_ms = now_ms;
            end
            r.trig   = trig;
            r.valid  = recorded;
            r.tmo    = from_timeout;
            r.raw    = rec_distance;
            r.smooth = smoothed;
            pending.push_back(r);
        endfunction

        function void check_result(ranger_result_t got);
            ranger_result_t exp;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: trig %0b valid %0b tmo %0b raw %0d smooth %0d",
                             got.trig, got.valid, got.tmo, got.raw, got.smooth);
                return;
            end
            exp = pending.pop_front();
            if (got.trig !== exp.trig || got.valid !== exp.valid || got.tmo !== exp.tmo ||
                got.raw !== exp.raw || got.smooth !== exp.smooth) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: expected trig %0b valid %0b tmo %0b raw %0d smooth %0d",
                             exp.trig, exp.valid, exp.tmo, exp.raw, exp.smooth);
                    $display("          actual   trig %0b valid %0b tmo %0b raw %0d smooth %0d",
                             got.trig, got.valid, got.tmo, got.raw, got.smooth);
                end
            end
        endfunction
    endclass

    logic        aclk                = 1'b0;
    logic        aresetn             = 1'b0;
    logic        cfg_valid           = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index           = CFG_PING_INTERVAL;
    logic [15:0] cfg_data            = '0;
    logic        s_valid             = 1'b0;
    logic        s_ready;
    logic [31:0] s_time_ms           = '0;
    logic [31:0] s_time_us           = '0;
    logic        s_echo_level        = 1'b0;
    logic        m_valid;
    logic        m_ready             = 1'b0;
    logic        m_trig_level;
    logic        m_sample_valid;
    logic        m_timed_out;
    logic [13:0] m_raw_distance;
    logic [13:0] m_smoothed_distance;

    ranger_scoreboard #(.DEPTH(WINDOW)) sb;
    int          send_idle_pct = 36;
    int          recv_idle_pct = 60;
    bit          hold_request  = 1'b0;
    int          cycle_count   = 0;
    logic [31:0] cur_ms        = '0;
    logic [31:0] cur_us        = '0;

    ultrasonic_ping_ranger_median_ema #(.WINDOW_SIZE(WINDOW)) dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_time_ms           (s_time_ms),
        .s_time_us           (s_time_us),
        .s_echo_level        (s_echo_level),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_trig_level        (m_trig_level),
        .m_sample_valid      (m_sample_valid),
        .m_timed_out         (m_timed_out),
        .m_raw_distance      (m_raw_distance),
        .m_smoothed_distance (m_smoothed_distance)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : result_sink
        ranger_result_t seen;
        int             held;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                seen = {m_trig_level, m_sample_valid, m_timed_out, m_raw_distance,
                        m_smoothed_distance};
                sb.check_result(seen);
            end
            if (hold_request) begin
                // long backpressure: a result waits in the output register and the next one stalls behind it
                hold_request = 1'b0;
                m_ready <= 1'b0;
                held = 0;
                while (held < LONG_HOLD_CYCLES) begin
                    @(posedge aclk);
                    held++;
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_sample(input logic [31:0] ms, input logic [31:0] us, input logic echo);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_time_ms    <= ms;
        s_time_us    <= us;
        s_echo_level <= echo;
        do @(posedge aclk); while (!s_ready);
        sb.note_sample(ms, us, echo);
        cur_ms = ms;
        cur_us = us;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, data);
    endtask

    task automatic apply_config(input logic [15:0] interval, input logic [15:0] timeout,
                                input logic [15:0] min_d, input logic [15:0] max_d,
                                input logic [15:0] gain, input bit stray);
        write_reg(CFG_PING_INTERVAL, interval);
        write_reg(CFG_ECHO_TIMEOUT, timeout);
        write_reg(CFG_MIN_DISTANCE, min_d);
        write_reg(CFG_MAX_DISTANCE, max_d);
        write_reg(CFG_SMOOTH_GAIN, gain);
        if (stray)
            write_reg(CFG_STRAY_INDEX, 16'hFFFF);
        cfg_valid <= 1'b0;
    endtask

    // stop offering requests, wait for every result, then let the block settle
    task automatic drain_results();
        s_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // mostly well-formed ping sequences steered by the predicted phase, some noise
    task automatic run_pings(input int count);
        logic [31:0] ms;
        logic [31:0] us;
        logic        echo;
        int          pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            ms   = cur_ms + $urandom_range(0, 1);
            us   = cur_us + $urandom_range(1, 40);
            echo = 1'($urandom_range(1));
            if (pick < 8) begin
                ms = $urandom;
                us = $urandom;
            end else begin
                case (sb.phase)
                    PH_IDLE: begin
                        us   = cur_us + $urandom_range(1, 2000);
                        ms   = sb.last_ping_ms + sb.ping_interval + $urandom_range(0, 2);
                        echo = 1'b0;
                        if (pick < 20)
                            echo = 1'b1;
                        else if (pick < 32 && sb.ping_interval != 0)
                            ms = sb.last_ping_ms + $urandom_range(0, sb.ping_interval - 1);
                        else if (pick < 38)
                            ms = ms + $urandom;
                    end
                    PH_TRIG: us = cur_us + $urandom_range(0, 6);
                    PH_WAIT_START: begin
                        echo = (pick < 50);
                        us   = cur_us + $urandom_range(1, 400);
                        if (pick >= 92) begin
                            echo = 1'b0;
                            us   = sb.trig_start_us + ECHO_START_TIMEOUT_US + (pick % 2);
                        end
                    end
                    default: begin
                        if (pick >= 90) begin
                            echo = 1'b1;
                            us   = sb.echo_start_us + sb.echo_timeout + (pick % 2);
                        end else if (pick < 45) begin
                            echo = 1'b1;
                            us   = cur_us + $urandom_range(1, 3000);
                        end else begin
                            echo = 1'b0;
                            case ($urandom_range(3))
                                0: us = sb.echo_start_us + $urandom_range(0, 200);
                                1: us = sb.echo_start_us + $urandom_range(200, 30000);
                                2: us = sb.echo_start_us + $urandom_range(30000, 65535);
                                default: us = sb.echo_start_us + $urandom;
                            endcase
                        end
                    end
                endcase
            end
            send_sample(ms, us, echo);
        end
    endtask

    initial begin : stimulus
        sb = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: counter wraps, pulse and timeout boundaries, clamps
        send_sample(32'd0, 32'd0, 1'b0);
        send_sample('1, 32'hFFFF_FFF0, 1'b1);   // echo high holds off the ping
        send_sample('1, 32'hFFFF_FFF8, 1'b0);   // trigger
        send_sample('1, 32'h0000_0003, 1'b1);   // 11 us across the us wrap
        send_sample('1, 32'h0000_0004, 1'b0);   // 12 us ends the pulse
        send_sample('1, 32'd49992, 1'b0);       // exactly 50000 us: keep waiting
        send_sample('1, 32'd49993, 1'b0);       // echo never started
        send_sample(32'd58, 32'd60000, 1'b0);   // 59 ms across the ms wrap: too soon
        send_sample(32'd59, 32'd100000, 1'b0);
        send_sample(32'd59, 32'd100012, 1'b1);
        send_sample(32'd59, 32'd100020, 1'b1);
        send_sample(32'd59, 32'd130020, 1'b1);  // echo high exactly at the timeout
        send_sample(32'd59, 32'd130021, 1'b1);  // echo never ended
        send_sample(32'd119, 32'd200000, 1'b0);
        send_sample(32'd119, 32'd200012, 1'b0);
        send_sample(32'd119, 32'd200100, 1'b1);
        send_sample(32'd119, 32'd200100, 1'b0); // zero-length echo, min clamp
        send_sample(32'd179, 32'd300000, 1'b0);
        send_sample(32'd179, 32'd300012, 1'b0);
        send_sample(32'd179, 32'd300050, 1'b1);
        send_sample(32'd179, 32'd365585, 1'b0); // long echo, max clamp
        send_sample(32'd239, 32'd400000, 1'b0);
        send_sample(32'd239, 32'd400012, 1'b0);
        send_sample(32'd239, 32'd400100, 1'b1);
        send_sample(32'd239, 32'd403000, 1'b0);
        drain_results();

        apply_config(16'd1, 16'd1, 16'd0, 16'd16383, 16'd256, 1'b0);
        run_pings(PHASE_ITEMS);
        drain_results();

        // zero interval and timeout, min above max, gain above one, stray index
        apply_config(16'd0, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 1'b1);
        run_pings(PHASE_ITEMS);
        drain_results();

        send_idle_pct = 60;
        recv_idle_pct = 36;
        apply_config(16'hFFFF, 16'hFFFF, 16'd0, 16'd16383, 16'd0, 1'b0);
        run_pings(PHASE_ITEMS);
        drain_results();

        apply_config(16'($urandom_range(1, 100)), 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 800)), 16'($urandom_range(0, 16383)),
                     16'($urandom_range(0, 300)), 1'b0);
        run_pings(PHASE_ITEMS);
        drain_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        apply_config(16'($urandom_range(1, 100)), 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 800)), 16'($urandom_range(800, 16383)),
                     16'($urandom_range(0, 256)), 1'b0);
        hold_request = 1'b1;
        run_pings(PHASE_ITEMS);
        drain_results();

        apply_config(16'd60, 16'($urandom_range(1000, 40000)), 16'd32,
                     16'($urandom_range(0, 16383)), 16'($urandom_range(1, 255)), 1'b0);
        run_pings(PHASE_ITEMS);
        drain_results();

        if (sb.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
